### hw/rtl/psched_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psched_pkg
// Types and constants shared by the preemptive priority scheduler modules.
// ----------------------------------------------------------------------------
package psched_pkg;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [15:0] WAIT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_ADMIT  = 2'd0,
		ST_REJECT = 2'd1,
		ST_RAN    = 2'd2,
		ST_IDLE   = 2'd3
	} sched_status_t;

	typedef struct packed {
		logic [15:0] pid;
		logic [15:0] left;
		logic [7:0]  prio;
		logic [15:0] wait_cnt;
	} entry_t;

	typedef struct packed {
		sched_status_t status;
		logic [15:0]   pid;
		logic [15:0]   left;
		logic          finished;
		logic [15:0]   wait_cnt;
		logic          preempted;
	} result_t;

	typedef struct packed {
		logic accept;
		logic dispatch;
		logic pass_start;
		logic scan_run;
		logic pick;
		logic update_run;
		logic commit;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic empty;
		logic pass_done;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/psched_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psched_ctrl
// Controller state machine: sequences dispatch, scan, pick, update and
// result hand-off for one word at a time.
// ----------------------------------------------------------------------------
module psched_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire psched_pkg::dp_status_t sts,
	output psched_pkg::ctrl_cmd_t       cmd
);
	import psched_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SCAN     = 6'b000100,
		S_PICK     = 6'b001000,
		S_UPDATE   = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.dispatch   = 1'b1;
				cmd.pass_start = 1'b1;
				if (sts.is_tick && !sts.empty) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.pass_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				cmd.pick       = 1'b1;
				cmd.pass_start = 1'b1;
				state_d        = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update_run = 1'b1;
				if (sts.pass_done) begin
					cmd.commit = 1'b1;
					state_d    = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/psched_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psched_dp
// Datapath: job table memory, scan pointer, selection registers, running
// job state and the output register.
// ----------------------------------------------------------------------------
module psched_dp #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire psched_pkg::ctrl_cmd_t               cmd,
	output psched_pkg::dp_status_t                   sts,
	input  wire logic                                in_user,
	input  wire logic [psched_pkg::IN_DATA_W-1:0]    in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [psched_pkg::OUT_DATA_W-1:0]        out_data,
	output logic [1:0]                               out_user
);
	import psched_pkg::*;

	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int IW = $clog2(TABLE_SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

	entry_t mem [TABLE_SLOTS];

	logic        cmd_q;
	logic [15:0] in_pid_q;
	logic [15:0] in_burst_q;
	logic [7:0]  in_prio_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	entry_t        rd_s1;

	logic          found_q;
	entry_t        fnd_q;
	logic [IW-1:0] fnd_idx_q;
	entry_t        best_q;
	logic [IW-1:0] best_idx_q;

	logic          run_active_q;
	logic [15:0]   run_id_q;
	logic [IW-1:0] sel_idx_q;
	logic [15:0]   sel_left_q;
	logic          done_q;

	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	logic          pass_run;
	logic          rd_issue;
	logic          full;
	logic          preempt_c;
	entry_t        sel_c;
	logic [IW-1:0] sel_idx_c;
	logic          done_c;
	logic [15:0]   new_left_c;
	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;

	assign pass_run = cmd.scan_run || cmd.update_run;
	assign rd_issue = pass_run && (rd_ptr_q < count_q);
	assign full     = (count_q == SLOTS_C);

	assign sts.is_tick   = (cmd_q == CMD_TICK);
	assign sts.empty     = (count_q == '0);
	assign sts.pass_done = (rd_ptr_q == count_q) && !vld_s1;
	assign sts.out_free  = !out_valid_q || out_ready;

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q      <= in_user;
			in_pid_q   <= in_data[15:0];
			in_burst_q <= in_data[31:16];
			in_prio_q  <= in_data[39:32];
		end
	end

	// pick the served job from the scan results
	always_comb begin
		preempt_c = 1'b0;
		sel_c     = best_q;
		sel_idx_c = best_idx_q;
		priority if (found_q && (best_q.prio < fnd_q.prio)) begin
			preempt_c = 1'b1;
		end else if (found_q) begin
			sel_c     = fnd_q;
			sel_idx_c = fnd_idx_q;
		end
		done_c     = (sel_c.left <= 16'd1);
		new_left_c = done_c ? 16'd0 : (sel_c.left - 16'd1);
	end

	// memory write port
	always_comb begin
		we    = 1'b0;
		waddr = rd_s1.pid[IW-1:0];
		wdata = rd_s1;
		if (cmd.dispatch && !sts.is_tick && !full) begin
			we             = 1'b1;
			waddr          = count_q[IW-1:0];
			wdata.pid      = in_pid_q;
			wdata.left     = in_burst_q;
			wdata.prio     = in_prio_q;
			wdata.wait_cnt = '0;
		end else if (cmd.update_run && vld_s1) begin
			if (idx_s1 == sel_idx_q) begin
				we         = !done_q;
				waddr      = idx_s1;
				wdata.left = sel_left_q;
			end else begin
				we = 1'b1;
				if (done_q && (idx_s1 > sel_idx_q)) begin
					waddr = idx_s1 - IW'(1);
				end else begin
					waddr = idx_s1;
				end
				if (rd_s1.wait_cnt != WAIT_MAX) begin
					wdata.wait_cnt = rd_s1.wait_cnt + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_issue) begin
			rd_s1 <= mem[rd_ptr_q[IW-1:0]];
		end
	end

	// scan pointer and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
		end else if (cmd.pass_start) begin
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
		end else if (pass_run) begin
			vld_s1 <= rd_issue;
			if (rd_issue) begin
				idx_s1   <= rd_ptr_q[IW-1:0];
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
		end
	end

	// running job search and earliest minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.pass_start) begin
			found_q <= 1'b0;
		end else if (cmd.scan_run && vld_s1 && run_active_q && !found_q
				&& (rd_s1.pid == run_id_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && vld_s1) begin
			if (run_active_q && !found_q && (rd_s1.pid == run_id_q)) begin
				fnd_q     <= rd_s1;
				fnd_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (rd_s1.prio < best_q.prio)) begin
				best_q     <= rd_s1;
				best_idx_q <= idx_s1;
			end
		end
		if (cmd.pick) begin
			sel_idx_q  <= sel_idx_c;
			sel_left_q <= new_left_c;
		end
	end

	// table count, running job and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			run_active_q <= 1'b0;
			run_id_q     <= '0;
			done_q       <= 1'b0;
			res_q        <= '0;
		end else begin
			if (cmd.dispatch) begin
				if (!sts.is_tick) begin
					res_q <= '{status: (full ? ST_REJECT : ST_ADMIT), pid: in_pid_q,
						default: '0};
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end else if (sts.empty) begin
					res_q        <= '{status: ST_IDLE, default: '0};
					run_active_q <= 1'b0;
				end else begin
					res_q <= '0;
				end
			end
			if (cmd.pick) begin
				run_active_q    <= !done_c;
				run_id_q        <= sel_c.pid;
				done_q          <= done_c;
				res_q.status    <= ST_RAN;
				res_q.pid       <= sel_c.pid;
				res_q.left      <= new_left_c;
				res_q.finished  <= done_c;
				res_q.wait_cnt  <= done_c ? sel_c.wait_cnt : 16'd0;
				res_q.preempted <= preempt_c;
			end
			if (cmd.commit && done_q) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_q.status;
	assign out_data  = {6'd0, out_q.preempted, out_q.wait_cnt, out_q.finished,
			out_q.left, out_q.pid};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_C)
		else $error("table count above capacity");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CW'(idx_s1) < count_q))
		else $error("read stage beyond table count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && done_q) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("finished job not removed");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending word");
`endif

endmodule
`default_nettype wire

### hw/rtl/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Admit, reject and idle tick pass through the dispatch and response states into the
// output register. A tick with ready jobs also makes two passes, scan and update, over
// the job table memory, one entry per cycle on its single read port.
// One word is worked on at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; table empty, no running job, no result pending.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a table of ready jobs in arrival order.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// proc_id, burst_length, priority_level
	input  wire logic [psched_pkg::IN_DATA_W-1:0]  s_tdata,
	// command
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// run_pid, time_left, finished, wait_total, preempted, zero pad
	output logic [psched_pkg::OUT_DATA_W-1:0]      m_tdata,
	// status
	output logic [1:0]                             m_tuser
);
	import psched_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	psched_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psched_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_user   (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
`default_nettype wire

### dv/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// Drives admit and tick words into the scheduler and keeps a shadow job table
// that predicts every result word. Each word is checked field by field against
// the oldest prediction. The run opens with directed cases (empty table, zero
// burst, duplicate ids, field extremes, a long output stall) and then sends
// random traffic in phases with neither, sender idling, receiver stalls or both.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
	import psched_pkg::*;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 60;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// proc_id, burst_length, priority_level
	logic [IN_DATA_W-1:0]  s_tdata;
	// command
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// run_pid, time_left, finished, wait_total, preempted, zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// status
	logic [1:0]            m_tuser;

	// shadow job table
	logic [15:0] tbl_pid   [SLOTS];
	logic [15:0] tbl_left  [SLOTS];
	logic [7:0]  tbl_prio  [SLOTS];
	logic [15:0] tbl_wait  [SLOTS];
	int          tbl_count;
	bit          run_active;
	logic [15:0] run_id;

	result_t pending_results[$];
	result_t want;
	result_t got;

	int fail_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int holdoff_cycles;
	int n_admit;
	int n_reject;
	int n_ran;
	int n_idle;
	int n_finished;
	int n_preempt;

	preemptive_priority_scheduler #(
		.TABLE_SLOTS(SLOTS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t schedule_step(input logic cmd, input logic [15:0] pid,
		input logic [15:0] burst, input logic [7:0] prio);
		result_t r;
		int sel;
		int best;
		bit found;
		r = '0;
		sel = 0;
		found = 1'b0;
		if (cmd == CMD_ADMIT) begin
			r.pid = pid;
			if (tbl_count >= SLOTS) begin
				r.status = ST_REJECT;
			end else begin
				tbl_pid[tbl_count]  = pid;
				tbl_left[tbl_count] = burst;
				tbl_prio[tbl_count] = prio;
				tbl_wait[tbl_count] = '0;
				tbl_count++;
				r.status = ST_ADMIT;
			end
			return r;
		end
		if (tbl_count == 0) begin
			run_active = 1'b0;
			r.status = ST_IDLE;
			return r;
		end
		if (run_active) begin
			for (int i = 0; i < tbl_count; i++) begin
				if (!found && tbl_pid[i] == run_id) begin
					sel = i;
					found = 1'b1;
				end
			end
		end
		best = 0;
		for (int i = 1; i < tbl_count; i++) begin
			if (tbl_prio[i] < tbl_prio[best]) begin
				best = i;
			end
		end
		if (!found) begin
			sel = best;
		end else if (tbl_prio[best] < tbl_prio[sel]) begin
			sel = best;
			r.preempted = 1'b1;
		end
		run_active = 1'b1;
		run_id = tbl_pid[sel];
		for (int i = 0; i < tbl_count; i++) begin
			if (i != sel && tbl_wait[i] != WAIT_MAX) begin
				tbl_wait[i]++;
			end
		end
		r.status = ST_RAN;
		r.pid = tbl_pid[sel];
		if (tbl_left[sel] <= 16'd1) begin
			tbl_left[sel] = '0;
			r.finished = 1'b1;
			r.wait_cnt = tbl_wait[sel];
			for (int i = sel; i + 1 < tbl_count; i++) begin
				tbl_pid[i]  = tbl_pid[i + 1];
				tbl_left[i] = tbl_left[i + 1];
				tbl_prio[i] = tbl_prio[i + 1];
				tbl_wait[i] = tbl_wait[i + 1];
			end
			tbl_count--;
			run_active = 1'b0;
		end else begin
			tbl_left[sel]--;
			r.left = tbl_left[sel];
		end
		return r;
	endfunction

	task automatic send_word(input logic cmd, input logic [15:0] pid,
		input logic [15:0] burst, input logic [7:0] prio);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {prio, burst, pid};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(schedule_step(cmd, pid, burst, prio));
	endtask

	task automatic stop_offer();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_val,
		input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s expected %0d got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				m_tready <= 1'b0;
				holdoff_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.status    = sched_status_t'(m_tuser);
			got.pid       = m_tdata[15:0];
			got.left      = m_tdata[31:16];
			got.finished  = m_tdata[32];
			got.wait_cnt  = m_tdata[48:33];
			got.preempted = m_tdata[49];
			if (pending_results.size() == 0) begin
				$error("result word with no expectation, status %0d", got.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("run_pid", want.pid, got.pid);
				check_field("time_left", want.left, got.left);
				check_field("finished", want.finished, got.finished);
				check_field("wait_total", want.wait_cnt, got.wait_cnt);
				check_field("preempted", want.preempted, got.preempted);
				case (want.status)
					ST_ADMIT:  n_admit++;
					ST_REJECT: n_reject++;
					ST_RAN:    n_ran++;
					default:   n_idle++;
				endcase
				n_finished += want.finished;
				n_preempt  += want.preempted;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_empty_tick();
		send_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_zero_burst();
		send_word(CMD_ADMIT, 16'hFFFF, 16'h0000, 8'hFF);
		send_word(CMD_TICK, 16'h0000, 16'h0000, 8'h00);
	endtask

	// same id twice; the first matching slot counts as running, the urgent one preempts
	task automatic test_duplicate_ids();
		send_word(CMD_ADMIT, 16'd5, 16'd3, 8'd9);
		send_word(CMD_TICK, 16'd0, 16'd0, 8'd0);
		send_word(CMD_ADMIT, 16'd5, 16'd2, 8'd2);
		repeat (5) send_word(CMD_TICK, 16'd0, 16'd0, 8'd0);
	endtask

	task automatic test_field_extremes();
		send_word(CMD_ADMIT, 16'h0000, 16'hFFFF, 8'hFF);
		send_word(CMD_ADMIT, 16'hA5A5, 16'd1, 8'h00);
		send_word(CMD_TICK, 16'h5A5A, 16'hA5A5, 8'h5A);
		send_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_word(CMD_ADMIT, 16'h5A5A, 16'd2, 8'h80);
		send_word(CMD_TICK, 16'h0000, 16'h0000, 8'h00);
		send_word(CMD_TICK, 16'h0000, 16'h0000, 8'h00);
	endtask

	// output held off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_cycles = 300;
		for (int k = 0; k < 12; k++) begin
			send_word(k % 3 == 2 ? CMD_TICK : CMD_ADMIT, 16'(1000 + k), 16'(k % 4 + 1),
				8'(k % 5));
		end
	endtask

	task automatic test_random_mix(input int n_words, input int send_pct, input int recv_pct);
		int admit_pct;
		int roll;
		logic cmd;
		logic [15:0] pid;
		logic [15:0] burst;
		logic [7:0] prio;
		admit_pct = 50;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int k = 0; k < n_words; k++) begin
			if (k % 50 == 0) begin
				case ($urandom_range(2))
					0:       admit_pct = 25;
					1:       admit_pct = 50;
					default: admit_pct = 80;
				endcase
			end
			cmd = ($urandom_range(99) < admit_pct) ? CMD_ADMIT : CMD_TICK;
			pid = ($urandom_range(9) < 3) ? 16'($urandom_range(7)) : 16'($urandom_range(65535));
			prio = ($urandom_range(9) < 6) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
			roll = $urandom_range(199);
			if (roll == 0) begin
				// long job kept at low urgency so it does not hog the table
				burst = 16'($urandom_range(65535));
				prio = 8'($urandom_range(200, 255));
			end else if (roll < 7) begin
				burst = '0;
			end else begin
				burst = 16'($urandom_range(1, 12));
			end
			send_word(cmd, pid, burst, prio);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		tbl_count = 0;
		run_active = 1'b0;
		run_id = '0;
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_cycles = 0;
		n_admit = 0;
		n_reject = 0;
		n_ran = 0;
		n_idle = 0;
		n_finished = 0;
		n_preempt = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_empty_tick();
		test_zero_burst();
		test_duplicate_ids();
		test_field_extremes();
		test_backpressure();
		test_random_mix(260, 0, 0);
		test_random_mix(260, 78, 0);
		test_random_mix(260, 0, 78);
		test_random_mix(260, 34, 34);
		stop_offer();

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d admits, %0d rejects, %0d served ticks, %0d idle ticks",
			n_admit, n_reject, n_ran, n_idle);
		$display("jobs completed %0d, preemptions seen %0d", n_finished, n_preempt);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
